// ===== design/bct_pkg.sv =====
// Shared constants and types for the Bezier curve tessellator.
package bct_pkg;
   localparam int MaxPoints = 8;
   localparam int FracBits  = 8;
   localparam int IdxW      = 3;
   localparam int CntW      = 4;
   localparam int CoordW    = 12;
   localparam int OutW      = 20;
   localparam int ArcW      = 27;
   localparam int TW        = 17;
   localparam int WorkW     = CoordW + FracBits;
   localparam int QualMax   = 8;
   localparam logic [ArcW-1:0] ArcMax = {ArcW{1'b1}};

   typedef logic [WorkW-1:0] work_type;
endpackage

// ===== design/bct_sqrt.sv =====
// Iterative rounded square root, one root bit per cycle.
module bct_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [41:0] radicand,
   output logic        done,
   output logic [21:0] root
);
   logic [41:0] v_ff, v_in;
   logic [43:0] r_ff, r_in;
   logic [43:0] bit_ff, bit_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [43:0] trial;

   // restoring digit recurrence, one step per cycle
   always_comb begin
      v_in = v_ff; r_in = r_ff; bit_in = bit_ff; run_in = run_ff; done_in = 1'b0;
      trial = r_ff + bit_ff;
      if (start) begin
         v_in = radicand; r_in = '0; bit_in = 44'd1 << 42; run_in = 1'b1;
      end else if (run_ff) begin
         if ({2'd0, v_ff} >= trial) begin
            v_in   = 42'({2'd0, v_ff} - trial);
            r_in   = (r_ff >> 1) + bit_ff;
         end else begin
            r_in   = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 44'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in; r_ff <= r_in; bit_ff <= bit_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = ({2'd0, v_ff} > r_ff) ? r_ff[21:0] + 22'd1 : r_ff[21:0];
endmodule

// ===== design/bezier_curve_tessellator_unit.sv =====
// Top level: point store, De Casteljau sequencer and arc length accumulation.
//  channel | ports               | handshake
//  request | req_point_x/y/final | start, busy
//  result  | rsp_curve_x/y, arc  | rsp_valid strobe
//  config  | csr_wr_en, wr_data  | write enable
// Points load one per cycle while not busy. A final point with n stored points
// (n of at least 2) runs (n-1)*q samples, q clamped to 1..8; each forms t
// (22-step divide, skipped when there is a single sample), copies the points,
// runs the n*(n-1)/2 lerps, takes a square root (skipped on the first sample)
// and emits. busy holds while a curve runs. No clearing pass after reset.
// The receiver cannot stall results.
module bezier_curve_tessellator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_point_x,
   input  logic [11:0] req_point_y,
   input  logic        req_final_point,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   output logic        rsp_valid,
   output logic [19:0] rsp_curve_x,
   output logic [19:0] rsp_curve_y,
   output logic [26:0] rsp_arc_length,
   output logic        rsp_run_end
);
   localparam logic [3:0] S_IDLE = 4'd0, S_TCALC = 4'd1, S_TFIX = 4'd2,
      S_LOAD = 4'd3, S_LRD = 4'd4, S_LMUL = 4'd5, S_LWR = 4'd6,
      S_RES = 4'd7, S_SQ = 4'd8, S_SQW = 4'd9, S_EMIT = 4'd10;

   localparam int IW = bct_pkg::IdxW;
   localparam int WW = bct_pkg::WorkW;

   logic [3:0]  st_ff, st_in;
   logic [3:0]  q_ff, q_in;
   logic [bct_pkg::CntW-1:0] cnt_ff, cnt_in;
   logic [bct_pkg::CntW-1:0] n_ff, n_in;
   logic [5:0]  tot_ff, tot_in, smp_ff, smp_in;
   logic [16:0] tq_ff, tq_in;
   logic [IW-1:0] k_ff, k_in, i_ff, i_in;
   logic [WW-1:0] px_ff, px_in, py_ff, py_in, ax_ff, ax_in, ay_ff, ay_in;
   logic [26:0] arc_ff, arc_in;
   logic [21:0] dnum_ff, dnum_in;
   logic [5:0]  drem_ff, drem_in;
   logic [4:0]  dcnt_ff, dcnt_in;
   logic [37:0] mx_ff, mx_in, my_ff, my_in;
   logic        first_ff, first_in;

   // control point store and work memory (x and y packed)
   logic [23:0] ctrl_mem [bct_pkg::MaxPoints];
   logic [2*WW-1:0] work_mem [bct_pkg::MaxPoints];
   logic [23:0] ctrl_rd_ff;
   logic [2*WW-1:0] wa_ff, wb_ff;
   logic [IW-1:0] rd_a, rd_b, wr_a;
   logic        work_we;
   logic [2*WW-1:0] work_wd;
   logic        sq_start, sq_done;
   logic [41:0] sq_rad;
   logic [21:0] sq_root;
   logic        accept;
   logic [WW-1:0] dx, dy;
   logic [5:0]  dmin;
   logic [6:0]  div_rem;
   logic        div_ge;
   logic [WW-1:0] nx, ny;
   logic [27:0] arc_sum;

   assign accept = start && !busy;
   assign busy   = (st_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (accept && cnt_ff < bct_pkg::CntW'(bct_pkg::MaxPoints))
         ctrl_mem[cnt_ff[IW-1:0]] <= {req_point_y, req_point_x};
      ctrl_rd_ff <= ctrl_mem[rd_a];
      if (work_we)
         work_mem[wr_a] <= work_wd;
      wa_ff <= work_mem[rd_a];
      wb_ff <= work_mem[rd_b];
   end

   assign dmin    = tot_ff - 6'd1;
   assign div_rem = {drem_ff, dnum_ff[21]};
   assign div_ge  = (div_rem >= {1'b0, dmin});
   assign dx     = (px_ff > ax_ff) ? px_ff - ax_ff : ax_ff - px_ff;
   assign dy     = (py_ff > ay_ff) ? py_ff - ay_ff : ay_ff - py_ff;
   assign sq_rad = 42'({22'd0, dx} * {22'd0, dx}) + 42'({22'd0, dy} * {22'd0, dy});
   assign arc_sum = {1'b0, arc_ff} + {6'd0, sq_root};
   assign nx = WW'((mx_ff + 38'd32768) >> 16);
   assign ny = WW'((my_ff + 38'd32768) >> 16);

   // sequencer
   always_comb begin
      st_in = st_ff; q_in = q_ff; cnt_in = cnt_ff; n_in = n_ff; tot_in = tot_ff;
      smp_in = smp_ff; tq_in = tq_ff; k_in = k_ff; i_in = i_ff;
      px_in = px_ff; py_in = py_ff; ax_in = ax_ff; ay_in = ay_ff; arc_in = arc_ff;
      dnum_in = dnum_ff; drem_in = drem_ff; dcnt_in = dcnt_ff;
      mx_in = mx_ff; my_in = my_ff; first_in = first_ff;
      rd_a = i_ff; rd_b = i_ff + IW'(1); wr_a = i_ff; work_we = 1'b0; work_wd = '0;
      sq_start = 1'b0;
      if (csr_wr_en) q_in = csr_wr_data;
      unique case (st_ff)
         S_IDLE: if (accept) begin
            if (cnt_ff < bct_pkg::CntW'(bct_pkg::MaxPoints)) cnt_in = cnt_ff + 1'b1;
            if (req_final_point) begin
               n_in = cnt_in; cnt_in = '0;
               if (n_in >= 2) begin
                  tot_in = 6'((n_in - 1'b1) *
                     ((q_ff == 0) ? 4'd1 : (q_ff > 4'd8) ? 4'd8 : q_ff));
                  smp_in = '0; arc_in = '0; first_in = 1'b1;
                  st_in = S_TCALC;
               end
            end
         end
         S_TCALC: begin
            // tq = floor((i*65536 + d/2) / d) by long division
            dnum_in = {smp_ff, 16'd0} + {17'd0, dmin[5:1]};
            drem_in = '0; dcnt_in = 5'd22;
            st_in = S_TFIX;
            if (dmin == 6'd0) begin
               tq_in = '0; i_in = '0; st_in = S_LOAD;
            end
         end
         S_TFIX: begin
            // one quotient bit per cycle
            drem_in = div_ge ? 6'(div_rem - {1'b0, dmin}) : div_rem[5:0];
            dnum_in = {dnum_ff[20:0], div_ge};
            dcnt_in = dcnt_ff - 5'd1;
            if (dcnt_ff == 5'd1) begin
               tq_in = dnum_in[16:0]; i_in = '0; st_in = S_LOAD;
            end
         end
         S_LOAD: begin
            // copy control points into work memory, one per cycle + latency
            rd_a = i_ff;
            k_in = 3'd1;
            i_in = i_ff + IW'(1);
            if (k_ff != 0 || i_ff != 0) begin
               work_we = 1'b1; wr_a = i_ff - IW'(1);
               work_wd = {ctrl_rd_ff[23:12], 8'd0, ctrl_rd_ff[11:0], 8'd0};
               if ({1'b0, wr_a} == n_ff - 4'd1) begin
                  k_in = '0; i_in = '0; st_in = S_LRD;
               end
            end
         end
         S_LRD: st_in = S_LMUL;
         S_LMUL: begin
            mx_in = 38'(wa_ff[WW-1:0] * (17'h10000 - tq_ff)) + 38'(wb_ff[WW-1:0] * tq_ff);
            my_in = 38'(wa_ff[2*WW-1:WW] * (17'h10000 - tq_ff)) +
                    38'(wb_ff[2*WW-1:WW] * tq_ff);
            st_in = S_LWR;
         end
         S_LWR: begin
            work_we = 1'b1; wr_a = i_ff; work_wd = {ny, nx};
            if ({1'b0, i_ff} + {1'b0, k_ff} + 4'd2 >= n_ff) begin
               i_in = '0; k_in = k_ff + IW'(1);
               if ({1'b0, k_ff} + 4'd2 >= n_ff) begin
                  st_in = S_RES;
                  px_in = nx; py_in = ny;
               end else st_in = S_LRD;
            end else begin
               i_in = i_ff + IW'(1); st_in = S_LRD;
            end
         end
         S_RES: begin
            if (first_ff) st_in = S_EMIT;
            else begin sq_start = 1'b1; st_in = S_SQ; end
         end
         S_SQ: if (sq_done) begin
            arc_in = (arc_sum > {1'b0, bct_pkg::ArcMax}) ? bct_pkg::ArcMax : arc_sum[26:0];
            st_in = S_EMIT;
         end
         S_EMIT: begin
            ax_in = px_ff; ay_in = py_ff; first_in = 1'b0;
            smp_in = smp_ff + 6'd1; k_in = '0; i_in = '0;
            st_in = (smp_ff + 6'd1 == tot_ff) ? S_IDLE : S_TCALC;
         end
         default: st_in = S_IDLE;
      endcase
   end

   bct_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sq_rad),
      .done(sq_done), .root(sq_root)
   );

   always_ff @(posedge clock) begin
      tot_ff <= tot_in; smp_ff <= smp_in; tq_ff <= tq_in; n_ff <= n_in;
      px_ff <= px_in; py_ff <= py_in; ax_ff <= ax_in; ay_ff <= ay_in;
      dnum_ff <= dnum_in; drem_ff <= drem_in; dcnt_ff <= dcnt_in;
      mx_ff <= mx_in; my_ff <= my_in; arc_ff <= arc_in;
      first_ff <= first_in; i_ff <= i_in;
      if (reset) begin
         st_ff <= S_IDLE; q_ff <= 4'd4; cnt_ff <= '0; k_ff <= '0;
      end else begin
         st_ff <= st_in; q_ff <= q_in; cnt_ff <= cnt_in; k_ff <= k_in;
      end
   end

   assign rsp_valid      = (st_ff == S_EMIT);
   assign rsp_curve_x    = px_ff;
   assign rsp_curve_y    = py_ff;
   assign rsp_arc_length = arc_ff;
   assign rsp_run_end    = (smp_ff + 6'd1 == tot_ff);
endmodule
